### hw/rtl/foct_pkg.sv
// Shared types and constants for the FOC coordinate transform core.
`timescale 1ns / 1ps
`default_nettype none

package foct_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        logic [2:0]              command;
        t_sample                 in_first;
        t_sample                 in_second;
        t_sample                 in_third;
        logic [ANGLE_WIDTH-1:0]  angle;
    } t_in_item;

    typedef struct packed {
        t_sample out_first;
        t_sample out_second;
        t_sample out_third;
        logic    saturated;
    } t_out_item;

    // Command codes
    localparam logic [2:0] CMD_CLARKE      = 3'd0;
    localparam logic [2:0] CMD_CLARKE_ZERO = 3'd1;
    localparam logic [2:0] CMD_INV_CLARKE  = 3'd2;
    localparam logic [2:0] CMD_PARK        = 3'd3;
    localparam logic [2:0] CMD_INV_PARK    = 3'd4;

    // Q30 coefficients
    localparam logic signed [30:0] INV_SQRT3_Q30  = 31'sd619925131;
    localparam logic signed [30:0] ONE_THIRD_Q30  = 31'sd357913941;
    localparam logic signed [30:0] HALF_SQRT3_Q30 = 31'sd929887697;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

endpackage

`default_nettype wire

### hw/rtl/foct_sincos.sv
// Quarter-wave sine ROM with registered read and quadrant folding.
`timescale 1ns / 1ps
`default_nettype none

module foct_sincos #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [foct_pkg::ANGLE_WIDTH-1:0]    i_angle,
    output foct_pkg::t_sample                        o_sin,
    output foct_pkg::t_sample                        o_cos
);

    localparam int SW        = foct_pkg::SAMPLE_WIDTH;
    localparam int NUM_STEPS = 1 << SINE_TABLE_BITS;
    localparam int ROM_DEPTH = NUM_STEPS + 1;
    localparam int AW        = SINE_TABLE_BITS + 1;
    localparam logic [AW-1:0] FULL_IDX = AW'(NUM_STEPS);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SW-2:0] t_rom [0:ROM_DEPTH-1];

    // Q30 Taylor series, nine terms, scaled to full sample amplitude
    function automatic logic [SW-2:0] table_entry(longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint signed   sum;
        longint signed   r;
        longint signed   amp;
        amp  = (64'sd1 <<< (SW - 1)) - 64'sd1;
        x    = (HALF_PI_Q30 * k + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = $signed(($unsigned(sum) * $unsigned(amp) + (64'd1 << 29)) >> 30);
        if (r > amp) begin
            r = amp;
        end
        return r[SW-2:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = table_entry(longint'(k));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [AW-1:0]              w_addr_i;
    logic [AW-1:0]              w_addr_m;
    logic [SW-2:0]              r_ti;
    logic [SW-2:0]              r_tm;
    logic [1:0]                 r_quad;
    foct_pkg::t_sample          w_pos_i;
    foct_pkg::t_sample          w_pos_m;

    assign w_idx    = i_angle[foct_pkg::ANGLE_WIDTH-3 -: SINE_TABLE_BITS];
    assign w_addr_i = {1'b0, w_idx};
    assign w_addr_m = FULL_IDX - w_addr_i;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ti   <= SINE_ROM[w_addr_i];
            r_tm   <= SINE_ROM[w_addr_m];
            r_quad <= i_angle[foct_pkg::ANGLE_WIDTH-1 -: 2];
        end
    end

    assign w_pos_i = {1'b0, r_ti};
    assign w_pos_m = {1'b0, r_tm};

    always_comb begin
        case (r_quad)
            2'd0: begin
                o_sin = w_pos_i;
                o_cos = w_pos_m;
            end
            2'd1: begin
                o_sin = w_pos_m;
                o_cos = -w_pos_i;
            end
            2'd2: begin
                o_sin = -w_pos_i;
                o_cos = -w_pos_m;
            end
            default: begin
                o_sin = -w_pos_m;
                o_cos = w_pos_i;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/foc_coordinate_transform_core.sv
// Top level: Clarke / Park frame transform pipeline with valid/ready channels.
// Path: an accepted transaction passes the stage 1, stage 2 and stage 3 registers before its result is offered.
// Throughput: one transaction per cycle; the three-stage pipeline stalls only on output backpressure.
// Stage 2 holds four multipliers, each used once per transaction; only m0 and m1 are shared between commands.
// Reset: i_rst_n synchronous, active low; clears the stage valid flags only.
// The sine table is a constant ROM, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module foc_coordinate_transform_core #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input channel
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire foct_pkg::t_in_item i_in_data,
    // result channel
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output foct_pkg::t_out_item o_out_data
);

    localparam int SW      = foct_pkg::SAMPLE_WIDTH;
    localparam int OPA_W   = SW + 2;       // holds A + 2B and A + B + C
    localparam int OPB_W   = 31;           // Q30 coefficients, signed
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] HALF_Q30 = ACC_W'(1) << 29;
    localparam logic signed [ACC_W-1:0] HALF_QS  = ACC_W'(1) << (foct_pkg::FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] LIM_HI   = ACC_W'(foct_pkg::SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] LIM_LO   = ACC_W'(foct_pkg::SAMPLE_MIN);

    // Pipeline flow control: each stage moves when the next one frees up.
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign w_adv3     = !r_v3 || i_out_ready;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_in_ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture operands; sine/cosine table read registers alongside.
    // ------------------------------------------------------------------
    logic [2:0]        r_cmd1;
    foct_pkg::t_sample r_x1;
    foct_pkg::t_sample r_y1;
    foct_pkg::t_sample r_z1;
    foct_pkg::t_sample w_sin;
    foct_pkg::t_sample w_cos;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_cmd1 <= i_in_data.command;
            r_x1   <= i_in_data.in_first;
            r_y1   <= i_in_data.in_second;
            r_z1   <= i_in_data.in_third;
        end
    end

    foct_sincos #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_en    (w_adv1),
        .i_angle (i_in_data.angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // ------------------------------------------------------------------
    // Stage 2: four multipliers, operands steered by command.
    //   m0: (A+2B)*1/sqrt3 | B*sqrt3/2 | x*cos
    //   m1: (A+B+C)*1/3    | y*sin
    //   m2: y*cos, m3: x*sin
    // ------------------------------------------------------------------
    logic signed [OPA_W-1:0]  w_sum_xy2;
    logic signed [OPA_W-1:0]  w_sum_xyz;
    logic signed [OPA_W-1:0]  w_opa0;
    logic signed [OPB_W-1:0]  w_opb0;
    logic signed [OPA_W-1:0]  w_opa1;
    logic signed [OPB_W-1:0]  w_opb1;
    logic signed [PROD_W-1:0] n_m0;
    logic signed [PROD_W-1:0] n_m1;
    logic signed [2*SW-1:0]   n_m2;
    logic signed [2*SW-1:0]   n_m3;
    logic [2:0]               r_cmd2;
    foct_pkg::t_sample        r_x2;
    logic signed [PROD_W-1:0] r_m0;
    logic signed [PROD_W-1:0] r_m1;
    logic signed [2*SW-1:0]   r_m2;
    logic signed [2*SW-1:0]   r_m3;

    assign w_sum_xy2 = OPA_W'(r_x1) + (OPA_W'(r_y1) <<< 1);
    assign w_sum_xyz = OPA_W'(r_x1) + OPA_W'(r_y1) + OPA_W'(r_z1);

    always_comb begin
        w_opa0 = OPA_W'(r_x1);
        w_opb0 = OPB_W'(w_cos);
        w_opa1 = OPA_W'(r_y1);
        w_opb1 = OPB_W'(w_sin);
        case (r_cmd1)
            foct_pkg::CMD_CLARKE, foct_pkg::CMD_CLARKE_ZERO: begin
                w_opa0 = w_sum_xy2;
                w_opb0 = foct_pkg::INV_SQRT3_Q30;
                w_opa1 = w_sum_xyz;
                w_opb1 = foct_pkg::ONE_THIRD_Q30;
            end
            foct_pkg::CMD_INV_CLARKE: begin
                w_opa0 = OPA_W'(r_y1);
                w_opb0 = foct_pkg::HALF_SQRT3_Q30;
            end
            default: begin
            end
        endcase
    end

    assign n_m0 = PROD_W'(w_opa0) * PROD_W'(w_opb0);
    assign n_m1 = PROD_W'(w_opa1) * PROD_W'(w_opb1);
    assign n_m2 = (2*SW)'(r_y1) * (2*SW)'(w_cos);
    assign n_m3 = (2*SW)'(r_x1) * (2*SW)'(w_sin);

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_cmd2 <= r_cmd1;
            r_x2   <= r_x1;
            r_m0   <= n_m0;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_m3   <= n_m3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: combine, round half up, saturate.
    // ------------------------------------------------------------------
    function automatic logic [SW:0] rnd_clip(logic signed [ACC_W-1:0] v, logic q30);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] sh;
        t  = v + (q30 ? HALF_Q30 : HALF_QS);
        sh = q30 ? (t >>> 30) : (t >>> foct_pkg::FRAC_BITS);
        if (sh > LIM_HI) begin
            return {1'b1, foct_pkg::SAMPLE_MAX};
        end else if (sh < LIM_LO) begin
            return {1'b1, foct_pkg::SAMPLE_MIN};
        end
        return {1'b0, sh[SW-1:0]};
    endfunction

    logic                    w_q30;
    logic signed [ACC_W-1:0] w_xq29;
    logic signed [ACC_W-1:0] w_v1;
    logic signed [ACC_W-1:0] w_v2;
    logic signed [ACC_W-1:0] w_v3;
    logic [SW:0]             w_rc1;
    logic [SW:0]             w_rc2;
    logic [SW:0]             w_rc3;
    foct_pkg::t_out_item     n_out;
    foct_pkg::t_out_item     r_out;

    assign w_q30  = r_cmd2 inside {foct_pkg::CMD_CLARKE, foct_pkg::CMD_CLARKE_ZERO,
                                   foct_pkg::CMD_INV_CLARKE};
    assign w_xq29 = ACC_W'(r_x2) <<< 29;

    always_comb begin
        w_v1 = ACC_W'(r_m0) + ACC_W'(r_m1);
        w_v2 = ACC_W'(r_m0);
        w_v3 = ACC_W'(r_m1);
        case (r_cmd2)
            foct_pkg::CMD_INV_CLARKE: begin
                w_v2 = ACC_W'(r_m0) - w_xq29;
                w_v3 = -w_xq29 - ACC_W'(r_m0);
            end
            foct_pkg::CMD_PARK: begin
                w_v1 = ACC_W'(r_m0) + ACC_W'(r_m1);
                w_v2 = ACC_W'(r_m2) - ACC_W'(r_m3);
            end
            foct_pkg::CMD_INV_PARK: begin
                w_v1 = ACC_W'(r_m0) - ACC_W'(r_m1);
                w_v2 = ACC_W'(r_m3) + ACC_W'(r_m2);
            end
            default: begin
            end
        endcase
    end

    assign w_rc1 = rnd_clip(w_v1, w_q30);
    assign w_rc2 = rnd_clip(w_v2, w_q30);
    assign w_rc3 = rnd_clip(w_v3, w_q30);

    always_comb begin
        n_out = '0;
        case (r_cmd2)
            foct_pkg::CMD_CLARKE: begin
                n_out.out_first  = r_x2;
                n_out.out_second = w_rc2[SW-1:0];
                n_out.saturated  = w_rc2[SW];
            end
            foct_pkg::CMD_CLARKE_ZERO, foct_pkg::CMD_INV_CLARKE: begin
                n_out.out_first  = r_x2;
                n_out.out_second = w_rc2[SW-1:0];
                n_out.out_third  = w_rc3[SW-1:0];
                n_out.saturated  = w_rc2[SW] | w_rc3[SW];
            end
            foct_pkg::CMD_PARK, foct_pkg::CMD_INV_PARK: begin
                n_out.out_first  = w_rc1[SW-1:0];
                n_out.out_second = w_rc2[SW-1:0];
                n_out.saturated  = w_rc1[SW] | w_rc2[SW];
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // An empty output stage means nothing can block the input side.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // An accepted transaction lands in stage 1.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted transaction lost at stage 1");

    // A new result only appears if stage 2 held a transaction.
    a_result_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v2))
        else $error("result invented without stage 2 transaction");

    // Saturation flag implies some field sits at a rail.
    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |->
            (o_out_data.out_first == foct_pkg::SAMPLE_MAX ||
             o_out_data.out_first == foct_pkg::SAMPLE_MIN ||
             o_out_data.out_second == foct_pkg::SAMPLE_MAX ||
             o_out_data.out_second == foct_pkg::SAMPLE_MIN ||
             o_out_data.out_third == foct_pkg::SAMPLE_MAX ||
             o_out_data.out_third == foct_pkg::SAMPLE_MIN))
        else $error("saturated flag without clipped field");
`endif

endmodule

`default_nettype wire

### tb/sv/foct_transform_checker.sv
// Transaction monitor and frame-transform predictor for the FOC coordinate transform core.
`timescale 1ns / 1ps

module foct_transform_checker #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_ready,
    input  foct_pkg::t_in_item  i_in_data,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_ready,
    input  foct_pkg::t_out_item i_out_data,
    output int                  o_pending,
    output int                  o_mismatch_count
);
    import foct_pkg::*;

    localparam int TABLE_LEN = 1 << SINE_TABLE_BITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    longint    sine_rom [0:TABLE_LEN];
    t_out_item expected_results [$];
    int        pending_count  = 0;
    int        mismatch_count = 0;

    assign o_pending        = pending_count;
    assign o_mismatch_count = mismatch_count;

    // Quarter-wave table from a Q30 Taylor series, scaled to full-scale samples.
    initial begin : build_sine_rom
        longint unsigned x, x2, term;
        longint          sum, amp, r;
        amp = (longint'(1) <<< FRAC_BITS) - 1;
        for (int k = 0; k <= TABLE_LEN; k++) begin
            x = (HALF_PI_Q30 * longint'(k) + longint'(TABLE_LEN >> 1)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int i = 1; i <= 8; i++) begin
                term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
                if (i % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum * amp + (longint'(1) <<< 29)) >>> 30;
            sine_rom[k] = (r > amp) ? amp : r;
        end
    end

    // floor((v + half) / 2^f)
    function automatic longint round_half_up(input longint v, input int f);
        return (v + (longint'(1) <<< (f - 1))) >>> f;
    endfunction

    function automatic t_sample clip_sample(input longint v, inout logic clipped);
        if (v > longint'(SAMPLE_MAX)) begin
            clipped = 1'b1;
            return SAMPLE_MAX;
        end
        if (v < longint'(SAMPLE_MIN)) begin
            clipped = 1'b1;
            return SAMPLE_MIN;
        end
        return t_sample'(v);
    endfunction

    function automatic t_out_item predict_frame_result(input t_in_item item);
        t_out_item       res;
        longint          a, b, c, sn, cs, ti, tm;
        longint unsigned low, idx;
        int              rest;
        logic            clipped;
        res     = '0;
        clipped = 1'b0;
        a  = longint'(item.in_first);
        b  = longint'(item.in_second);
        c  = longint'(item.in_third);
        // angle: two quadrant bits, then the table index, truncated
        rest = ANGLE_WIDTH - 2;
        low  = longint'(item.angle) & ((longint'(1) <<< rest) - 1);
        if (rest >= SINE_TABLE_BITS) begin
            idx = low >> (rest - SINE_TABLE_BITS);
        end else begin
            idx = low << (SINE_TABLE_BITS - rest);
        end
        idx = idx & longint'(TABLE_LEN - 1);
        ti  = sine_rom[idx];
        tm  = sine_rom[TABLE_LEN - idx];
        case (item.angle[ANGLE_WIDTH-1 -: 2])
            2'd0: begin sn = ti;  cs = tm;  end
            2'd1: begin sn = tm;  cs = -ti; end
            2'd2: begin sn = -ti; cs = -tm; end
            default: begin sn = -tm; cs = ti; end
        endcase
        case (item.command)
            CMD_CLARKE, CMD_CLARKE_ZERO: begin
                res.out_first  = item.in_first;
                res.out_second = clip_sample(round_half_up(
                    (a + 2 * b) * longint'(INV_SQRT3_Q30), 30), clipped);
                if (item.command == CMD_CLARKE_ZERO) begin
                    res.out_third = clip_sample(round_half_up(
                        (a + b + c) * longint'(ONE_THIRD_Q30), 30), clipped);
                end
            end
            CMD_INV_CLARKE: begin
                res.out_first  = item.in_first;
                res.out_second = clip_sample(round_half_up(
                    -a * (longint'(1) <<< 29) + b * longint'(HALF_SQRT3_Q30), 30), clipped);
                res.out_third  = clip_sample(round_half_up(
                    -a * (longint'(1) <<< 29) - b * longint'(HALF_SQRT3_Q30), 30), clipped);
            end
            CMD_PARK: begin
                res.out_first  = clip_sample(round_half_up(a * cs + b * sn, FRAC_BITS), clipped);
                res.out_second = clip_sample(round_half_up(b * cs - a * sn, FRAC_BITS), clipped);
            end
            CMD_INV_PARK: begin
                res.out_first  = clip_sample(round_half_up(a * cs - b * sn, FRAC_BITS), clipped);
                res.out_second = clip_sample(round_half_up(a * sn + b * cs, FRAC_BITS), clipped);
            end
            default: begin
            end
        endcase
        res.saturated = clipped;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_frame_result(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: nothing pending");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.out_first !== want.out_first) begin
                        $error("out_first: expected %0d, got %0d",
                               want.out_first, i_out_data.out_first);
                        mismatch_count++;
                    end
                    if (i_out_data.out_second !== want.out_second) begin
                        $error("out_second: expected %0d, got %0d",
                               want.out_second, i_out_data.out_second);
                        mismatch_count++;
                    end
                    if (i_out_data.out_third !== want.out_third) begin
                        $error("out_third: expected %0d, got %0d",
                               want.out_third, i_out_data.out_third);
                        mismatch_count++;
                    end
                    if (i_out_data.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, i_out_data.saturated);
                        mismatch_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

### tb/sv/tb_foc_coordinate_transform_core.sv
// Testbench top: stimulus, flow control and verdict for the FOC coordinate transform core.
`timescale 1ns / 1ps

module tb_foc_coordinate_transform_core;
    import foct_pkg::*;

    localparam int SINE_TABLE_BITS  = 10;
    localparam int RANDOM_PER_PHASE = 306;   // four phases, plus the directed set
    localparam int NUM_PHASES       = 4;

    // Per-phase idling, in percent of cycles: none, sender, receiver, both.
    localparam int SRC_IDLE_PCT  [NUM_PHASES] = '{0, 71, 0, 27};
    localparam int SINK_STALL_PCT[NUM_PHASES] = '{0, 0, 71, 27};

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int pending;
    int mismatches;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    foc_coordinate_transform_core #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // Watches both channels, predicts each result and counts mismatches.
    foct_transform_checker #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .o_pending       (pending),
        .o_mismatch_count(mismatches)
    );

    // Result side: ready is redrawn every falling edge, so stalls land on
    // any pipeline phase. With a zero stall rate ready stays high.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic t_in_item make_item(input logic [2:0] cmd, input t_sample a,
                                           input t_sample b, input t_sample c,
                                           input logic [ANGLE_WIDTH-1:0] ang);
        t_in_item item;
        item.command   = cmd;
        item.in_first  = a;
        item.in_second = b;
        item.in_third  = c;
        item.angle     = ang;
        return item;
    endfunction

    // Operand mix: rails hit often so the clipping paths get exercised,
    // small values for the linear region, the rest uniform.
    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return t_sample'($urandom_range(511)) - t_sample'(256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_in_item pick_item();
        logic [2:0] cmd;
        // about one transaction in twelve carries an unused command code
        if ($urandom_range(11) == 0) begin
            cmd = 3'($urandom_range(7, 5));
        end else begin
            cmd = 3'($urandom_range(4));
        end
        return make_item(cmd, pick_sample(), pick_sample(), pick_sample(),
                         ANGLE_WIDTH'($urandom));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // valid is only lowered for an idle gap, never between back-to-back items.
    task automatic send_transaction(input t_in_item item);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            in_data  <= pick_item();   // junk payload while idle
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // Sender holds off until every predicted result has been returned.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed set: rails per command, quadrant boundaries, odd codes.
        send_transaction(make_item(CMD_CLARKE, SAMPLE_MAX, SAMPLE_MAX, '0, '0));
        send_transaction(make_item(CMD_CLARKE, SAMPLE_MIN, SAMPLE_MIN, '0, '0));
        send_transaction(make_item(CMD_CLARKE, '0, '0, '0, '0));
        send_transaction(make_item(CMD_CLARKE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 16'hFFFF));
        send_transaction(make_item(CMD_CLARKE_ZERO, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0));
        send_transaction(make_item(CMD_CLARKE_ZERO, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, '0));
        send_transaction(make_item(CMD_CLARKE_ZERO, 16'sd1000, -16'sd500, -16'sd500, '0));
        send_transaction(make_item(CMD_INV_CLARKE, SAMPLE_MIN, SAMPLE_MAX, '0, '0));
        send_transaction(make_item(CMD_INV_CLARKE, SAMPLE_MAX, SAMPLE_MIN, '0, '0));
        send_transaction(make_item(CMD_INV_CLARKE, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, '0));
        send_transaction(make_item(CMD_PARK, SAMPLE_MAX, SAMPLE_MAX, '0, 16'h2000));
        send_transaction(make_item(CMD_PARK, SAMPLE_MIN, SAMPLE_MAX, '0, 16'h0000));
        send_transaction(make_item(CMD_PARK, SAMPLE_MIN, SAMPLE_MAX, '0, 16'h4000));
        send_transaction(make_item(CMD_PARK, SAMPLE_MIN, SAMPLE_MAX, '0, 16'h8000));
        send_transaction(make_item(CMD_PARK, SAMPLE_MIN, SAMPLE_MAX, '0, 16'hC000));
        send_transaction(make_item(CMD_PARK, SAMPLE_MIN, SAMPLE_MIN, '0, 16'hA000));
        send_transaction(make_item(CMD_INV_PARK, SAMPLE_MIN, SAMPLE_MIN, '0, 16'h6000));
        send_transaction(make_item(CMD_INV_PARK, SAMPLE_MAX, SAMPLE_MIN, '0, 16'hE000));
        send_transaction(make_item(CMD_INV_PARK, SAMPLE_MAX, '0, '0, 16'hFFFF));
        send_transaction(make_item(CMD_INV_PARK, 16'sd12345, -16'sd2345, '0, 16'h3FFF));
        send_transaction(make_item(3'd5, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 16'hFFFF));
        send_transaction(make_item(3'd6, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 16'h5555));
        send_transaction(make_item(3'd7, 16'sh5A5A, -16'sd1, 16'shA5A5, 16'hAAAA));
        wait_for_drain();

        // Random phases, each drained before the next idling mix.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            src_idle_pct   = SRC_IDLE_PCT[ph];
            sink_stall_pct = SINK_STALL_PCT[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_transaction(pick_item());
            end
            wait_for_drain();
        end

        // Nothing pending; allow the pipeline depth for any stray result.
        sink_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
